/* rtl/smr_pkg.sv */
package smr_pkg;

	localparam int CAP_W = 11;
	localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;
	localparam int HDR_BYTES = 3;

	localparam logic [1:0] ST_MID  = 2'd0;
	localparam logic [1:0] ST_PART = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;
	localparam logic [1:0] ST_REJ  = 2'd3;

	typedef struct packed {
		logic       func;
		logic [7:0] base_type;
		logic       is_cont;
		logic       slot_first;
		logic       slot_last;
		logic [7:0] data_byte;
		logic [9:0] read_index;
	} smr_in_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [7:0]       done_type;
		logic [CAP_W-1:0] done_length;
		logic [7:0]       read_data;
	} smr_out_t;

endpackage

/* rtl/smr_chan_if.sv */
interface smr_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* rtl/slot_message_reassembler.sv */
// Slot message reassembler.
// The req channel takes one beat per slot byte or per store read. A slot byte
// runs the header, sequence and length checks; each payload byte is written
// into the message store; a read beat fetches one stored byte by read_index.
// Every req beat yields exactly one rsp beat: a status for slot bytes (nonzero
// only on the last byte of a slot) or the stored byte for a read.
// The cfg channel writes the capacity register; it is always ready and must
// only be written while no beat is in flight.
// rsp valid rises in the cycle after req acceptance, as the outputs and the
// message store read are registered. Throughput is one beat per cycle.
// The output register lets a new req beat enter in the same cycle the
// waiting rsp beat is taken; when rsp is stalled, req ready drops.
// Reset clears all slot state and sets capacity to 1024. The store itself is
// not cleared; reading a byte never written returns an undefined value.
module slot_message_reassembler
	import smr_pkg::*;
#(
	parameter int MSG_BYTES = 1024
) (
	input logic         clk,
	input logic         arst_n,
	smr_chan_if.sink    req,
	smr_chan_if.source  rsp,
	smr_chan_if.sink    cfg
);

	localparam int AW  = $clog2(MSG_BYTES);
	localparam int CW  = $clog2(MSG_BYTES + 1);
	localparam int IW  = (AW > 10) ? AW : 10;
	localparam int EXW = 17;

	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_HDR  = 2'd1;
	localparam logic [1:0] MODE_DATA = 2'd2;
	localparam logic [1:0] MODE_DROP = 2'd3;

	logic [CAP_W-1:0] capacity_q;
	logic [7:0]       active_type_q;
	logic [15:0]      expected_total_q;
	logic [CW-1:0]    received_count_q;
	logic [7:0]       next_seq_q;
	logic [7:0]       slot_pos_q;
	logic [1:0]       slot_mode_q;
	logic [7:0]       len_low_q;

	logic [7:0]       store_q [MSG_BYTES];
	logic [7:0]       rd_data_q;

	logic             valid_s1;
	logic [1:0]       status_s1;
	logic [7:0]       done_type_s1;
	logic [CAP_W-1:0] done_length_s1;
	logic             rd_hit_s1;

	logic             accept;
	logic [7:0]       active_type_d;
	logic [15:0]      expected_total_d;
	logic [CW-1:0]    received_count_d;
	logic [7:0]       next_seq_d;
	logic [7:0]       slot_pos_d;
	logic [1:0]       slot_mode_d;
	logic [7:0]       len_low_d;
	logic [1:0]       status_d;
	logic [7:0]       done_type_d;
	logic [CAP_W-1:0] done_length_d;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [IW-1:0]    rd_index;
	logic             rd_in_range;
	logic [EXW-1:0]   cap_eff;

	assign accept    = req.valid && req.ready;
	assign req.ready = !valid_s1 || rsp.ready;
	assign cfg.ready = 1'b1;

	assign rd_index    = IW'(req.data.read_index);
	assign rd_in_range = EXW'(rd_index) < EXW'(MSG_BYTES);
	assign cap_eff     = (EXW'(capacity_q) > EXW'(MSG_BYTES)) ? EXW'(MSG_BYTES)
	                                                          : EXW'(capacity_q);

	always_comb begin
		active_type_d    = active_type_q;
		expected_total_d = expected_total_q;
		received_count_d = received_count_q;
		next_seq_d       = next_seq_q;
		slot_pos_d       = slot_pos_q;
		slot_mode_d      = slot_mode_q;
		len_low_d        = len_low_q;
		status_d         = ST_MID;
		done_type_d      = '0;
		done_length_d    = '0;
		wr_en            = 1'b0;
		wr_addr          = received_count_q[AW-1:0];

		if (req.data.slot_first || slot_mode_q == MODE_IDLE) begin
			slot_pos_d = '0;
			if (req.data.is_cont) begin
				if (active_type_q != 8'd0 && active_type_q == req.data.base_type &&
				    req.data.data_byte == next_seq_q) begin
					next_seq_d  = next_seq_q + 8'd1;
					slot_mode_d = MODE_DATA;
				end else begin
					active_type_d = '0;
					slot_mode_d   = MODE_DROP;
				end
			end else begin
				active_type_d = '0;
				len_low_d     = req.data.data_byte;
				slot_mode_d   = MODE_HDR;
			end
		end else begin
			case (slot_mode_q)
				MODE_HDR: begin
					if (slot_pos_q == 8'd1) begin
						expected_total_d = {req.data.data_byte, len_low_q};
					end else if (slot_pos_q == 8'(HDR_BYTES - 1)) begin
						if (req.data.data_byte != 8'd0 ||
						    EXW'(expected_total_q) > cap_eff) begin
							slot_mode_d = MODE_DROP;
						end else begin
							active_type_d    = req.data.base_type;
							received_count_d = '0;
							next_seq_d       = 8'd1;
							slot_mode_d      = MODE_DATA;
						end
					end
				end
				MODE_DATA: begin
					if (EXW'(received_count_q) < EXW'(expected_total_q) &&
					    EXW'(received_count_q) < EXW'(MSG_BYTES)) begin
						wr_en            = 1'b1;
						received_count_d = received_count_q + CW'(1);
					end
				end
				default: begin
				end
			endcase
		end

		if (slot_pos_d != 8'hFF) begin
			slot_pos_d = slot_pos_d + 8'd1;
		end

		if (req.data.slot_last) begin
			if (slot_mode_d == MODE_DATA) begin
				if (EXW'(received_count_d) >= EXW'(expected_total_d)) begin
					status_d      = ST_DONE;
					done_type_d   = active_type_d;
					done_length_d = expected_total_d[CAP_W-1:0];
					active_type_d = '0;
				end else begin
					status_d = ST_PART;
				end
			end else begin
				if (slot_mode_d == MODE_HDR) begin
					active_type_d = '0;
				end
				status_d = ST_REJ;
			end
			slot_mode_d = MODE_IDLE;
			slot_pos_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q       <= CAP_RESET;
			active_type_q    <= '0;
			expected_total_q <= '0;
			received_count_q <= '0;
			next_seq_q       <= '0;
			slot_pos_q       <= '0;
			slot_mode_q      <= MODE_IDLE;
			len_low_q        <= '0;
			valid_s1         <= 1'b0;
		end else begin
			if (cfg.valid) begin
				capacity_q <= cfg.data;
			end
			if (accept && !req.data.func) begin
				active_type_q    <= active_type_d;
				expected_total_q <= expected_total_d;
				received_count_q <= received_count_d;
				next_seq_q       <= next_seq_d;
				slot_pos_q       <= slot_pos_d;
				slot_mode_q      <= slot_mode_d;
				len_low_q        <= len_low_d;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_hit_s1 <= req.data.func && rd_in_range;
			if (req.data.func) begin
				status_s1      <= ST_MID;
				done_type_s1   <= '0;
				done_length_s1 <= '0;
			end else begin
				status_s1      <= status_d;
				done_type_s1   <= done_type_d;
				done_length_s1 <= done_length_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !req.data.func && wr_en) begin
			store_q[wr_addr] <= req.data.data_byte;
		end
		if (accept && req.data.func) begin
			rd_data_q <= store_q[rd_index[AW-1:0]];
		end
	end

	assign rsp.valid            = valid_s1;
	assign rsp.data.status      = status_s1;
	assign rsp.data.done_type   = done_type_s1;
	assign rsp.data.done_length = done_length_s1;
	assign rsp.data.read_data   = rd_hit_s1 ? rd_data_q : 8'd0;

endmodule

/* rtl/smr_check.sv */
module smr_check
	import smr_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_ready,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input smr_out_t rsp_data
);

	// A response beat can only appear after a request beat was taken.
	a_rsp_follows_req: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready))
		else $error("response beat without a request beat");

	// Only a completed message reports a type or a length.
	a_done_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.status != ST_DONE) |->
			(rsp_data.done_type == 8'd0 && rsp_data.done_length == '0))
		else $error("done fields set without a completed message");

	// Slot reports with a nonzero status never carry read data.
	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_data.status != ST_MID) |-> rsp_data.read_data == 8'd0)
		else $error("read data on a slot report");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
		else $error("stalled response beat changed");

endmodule

bind slot_message_reassembler smr_check u_smr_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
